[rtl/ibe_pkg.sv]
package ibe_pkg;

   localparam int BUFFER_DEPTH = 256;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int DATA_W       = 8;
   localparam int PTR_W        = 9;
   localparam int POS_W        = 8;
   localparam int MAX_RESULTS  = 6;
   localparam int LEFT_W       = $clog2(MAX_RESULTS + 1);
   localparam int SLOT_W       = $clog2(MAX_RESULTS);

   localparam logic [PTR_W-1:0] RX_LIMIT = PTR_W'(256);

   // input actions
   localparam logic [1:0] ACT_EVENT = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_ARM   = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_RX     = 2'd1;
   localparam logic [1:0] KIND_TXDONE = 2'd2;
   localparam logic [1:0] KIND_RXDONE = 2'd3;

   // where a queued result takes its data from
   localparam logic [1:0] SEL_LIT   = 2'd0;
   localparam logic [1:0] SEL_RAM_A = 2'd1;
   localparam logic [1:0] SEL_RAM_B = 2'd2;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] CSR_DEFAULT_BYTE = 2'd0;
   localparam logic [1:0] CSR_RX_CAPACITY  = 2'd1;
   localparam logic [1:0] CSR_RETRANSFER   = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] default_byte;
      logic [PTR_W-1:0]  rx_capacity;
      logic              retransfer_enable;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        sel;
      logic [DATA_W-1:0] data;
      logic [POS_W-1:0]  position;
      logic [PTR_W-1:0]  count;
   } slot_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [DATA_W-1:0] data;
      logic [POS_W-1:0]  position;
      logic [PTR_W-1:0]  count;
      logic              last;
   } rsp_type;

endpackage

[rtl/ibe_engine.sv]
module ibe_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_action,
   input  logic                             req_ev_tx_request,
   input  logic                             req_ev_rx_byte,
   input  logic                             req_ev_stop,
   input  logic                             req_ev_addr_match,
   input  logic                             req_master_reads,
   input  logic [ibe_pkg::DATA_W-1:0]       req_rx_data,
   input  logic [ibe_pkg::POS_W-1:0]        req_load_index,
   input  logic [ibe_pkg::DATA_W-1:0]       req_load_value,
   input  logic [ibe_pkg::PTR_W-1:0]        req_arm_length,
   input  ibe_pkg::cfg_type                 cfg,
   output logic                             emit_valid,
   output ibe_pkg::rsp_type                 emit,
   input  logic                             emit_take
);
   import ibe_pkg::*;

   logic [DATA_W-1:0] tx_mem [BUFFER_DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   logic [PTR_W-1:0] tx_len_ff, tx_len_in;
   logic [PTR_W-1:0] tx_ptr_ff, tx_ptr_in;
   logic [PTR_W-1:0] rx_ptr_ff, rx_ptr_in;
   logic             mw_ff, mw_in;

   slot_type          list_ff [MAX_RESULTS];
   slot_type          list_in [MAX_RESULTS];
   logic [LEFT_W-1:0] left_ff, left_in;

   // working values for the item at the input
   logic              accept;
   logic [PTR_W-1:0]  len_w, txp_w, rxp_w, cap_w;
   logic              mw_w;
   logic [PTR_W:0]    p1_w, len10_w;
   logic [LEFT_W-1:0] n_w;
   slot_type          new_list [MAX_RESULTS];
   logic [ADDR_W-1:0] addr_a, addr_b;
   logic              mem_re, mem_we;

   assign req_ready = (left_ff == '0) || ((left_ff == LEFT_W'(1)) && emit_take);
   assign accept    = req_valid && req_ready;

   always_comb begin
      len_w   = tx_len_ff;
      txp_w   = tx_ptr_ff;
      rxp_w   = rx_ptr_ff;
      mw_w    = mw_ff;
      n_w     = '0;
      addr_a  = '0;
      addr_b  = '0;
      p1_w    = {1'b0, tx_ptr_ff} + (PTR_W+1)'(1);
      len10_w = {1'b0, tx_len_ff};
      cap_w   = (cfg.rx_capacity > RX_LIMIT) ? RX_LIMIT : cfg.rx_capacity;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         new_list[i] = '0;
      end
      unique case (req_action)
         ACT_ARM: begin
            len_w = (req_arm_length > PTR_W'(BUFFER_DEPTH)) ? PTR_W'(BUFFER_DEPTH)
                                                             : req_arm_length;
            txp_w = '0;
         end
         ACT_EVENT: begin
            if (req_ev_tx_request) begin
               if (p1_w < len10_w) begin
                  txp_w  = p1_w[PTR_W-1:0];
                  addr_a = p1_w[ADDR_W-1:0];
                  new_list[n_w[SLOT_W-1:0]].kind = KIND_TX;
                  new_list[n_w[SLOT_W-1:0]].sel  = SEL_RAM_A;
                  n_w = n_w + LEFT_W'(1);
               end else begin
                  if (p1_w == len10_w) begin
                     new_list[n_w[SLOT_W-1:0]].kind  = KIND_TXDONE;
                     new_list[n_w[SLOT_W-1:0]].count = tx_ptr_ff;
                     n_w = n_w + LEFT_W'(1);
                  end
                  new_list[n_w[SLOT_W-1:0]].kind = KIND_TX;
                  new_list[n_w[SLOT_W-1:0]].data = cfg.default_byte;
                  n_w = n_w + LEFT_W'(1);
               end
            end
            if (req_ev_rx_byte && (rxp_w < cap_w)) begin
               new_list[n_w[SLOT_W-1:0]].kind     = KIND_RX;
               new_list[n_w[SLOT_W-1:0]].data     = req_rx_data;
               new_list[n_w[SLOT_W-1:0]].position = rxp_w[POS_W-1:0];
               n_w   = n_w + LEFT_W'(1);
               rxp_w = rxp_w + PTR_W'(1);
            end
            if (req_ev_stop) begin
               if (mw_w) begin
                  new_list[n_w[SLOT_W-1:0]].kind  = KIND_RXDONE;
                  new_list[n_w[SLOT_W-1:0]].count = rxp_w;
                  n_w   = n_w + LEFT_W'(1);
                  rxp_w = '0;
               end else if (cfg.retransfer_enable) begin
                  txp_w = '0;
               end
            end
            if (req_ev_addr_match) begin
               if (rxp_w != '0) begin
                  new_list[n_w[SLOT_W-1:0]].kind  = KIND_RXDONE;
                  new_list[n_w[SLOT_W-1:0]].count = rxp_w;
                  n_w = n_w + LEFT_W'(1);
               end
               if (req_master_reads) begin
                  new_list[n_w[SLOT_W-1:0]].kind = KIND_TX;
                  if (txp_w < len_w) begin
                     addr_b = txp_w[ADDR_W-1:0];
                     new_list[n_w[SLOT_W-1:0]].sel = SEL_RAM_B;
                  end else begin
                     new_list[n_w[SLOT_W-1:0]].data = cfg.default_byte;
                  end
                  n_w  = n_w + LEFT_W'(1);
                  mw_w = 1'b0;
               end else begin
                  mw_w  = 1'b1;
                  rxp_w = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign tx_len_in = accept ? len_w : tx_len_ff;
   assign tx_ptr_in = accept ? txp_w : tx_ptr_ff;
   assign rx_ptr_in = accept ? rxp_w : rx_ptr_ff;
   assign mw_in     = accept ? mw_w  : mw_ff;

   assign mem_re = accept && (req_action == ACT_EVENT);
   assign mem_we = accept && (req_action == ACT_LOAD) &&
                   ((PTR_W+1)'(req_load_index) < (PTR_W+1)'(BUFFER_DEPTH));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tx_mem[req_load_index[ADDR_W-1:0]] <= req_load_value;
      end
      if (mem_re) begin
         rd_a_ff <= tx_mem[addr_a];
         rd_b_ff <= tx_mem[addr_b];
      end
   end

   // result queue: load on accept, shift down as each word leaves
   always_comb begin
      left_in = left_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         list_in[i] = list_ff[i];
      end
      if (accept) begin
         left_in = n_w;
         for (int i = 0; i < MAX_RESULTS; i++) begin
            list_in[i] = new_list[i];
         end
      end else if (emit_take) begin
         left_in = left_ff - LEFT_W'(1);
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            list_in[i] = list_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         list_ff[i] <= list_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_len_ff <= '0;
         tx_ptr_ff <= '0;
         rx_ptr_ff <= '0;
         mw_ff     <= 1'b0;
         left_ff   <= '0;
      end else begin
         tx_len_ff <= tx_len_in;
         tx_ptr_ff <= tx_ptr_in;
         rx_ptr_ff <= rx_ptr_in;
         mw_ff     <= mw_in;
         left_ff   <= left_in;
      end
   end

   assign emit_valid    = (left_ff != '0);
   assign emit.kind     = list_ff[0].kind;
   assign emit.position = list_ff[0].position;
   assign emit.count    = list_ff[0].count;
   assign emit.last     = (left_ff == LEFT_W'(1));
   assign emit.data     = (list_ff[0].sel == SEL_RAM_A) ? rd_a_ff :
                          (list_ff[0].sel == SEL_RAM_B) ? rd_b_ff : list_ff[0].data;

endmodule

[rtl/i2c_target_buffer_engine_top.sv]
// I2C target buffer engine. One request word is taken per cycle whenever no earlier
// results are queued. A bus-event word that produces k results (0 to 5) holds the
// input until they have left the result queue, one per cycle while the output
// register is empty or being drained; the next word is taken in the cycle the last
// of them moves to the output register, which lets the input run ahead of a stalled
// rsp side by one queued word. All state updates for a word happen in the cycle it is
// taken. The transmit memory (256 bytes, one write port, two registered read ports)
// is not cleared at reset; reading a byte that was never loaded returns junk.
module i2c_target_buffer_engine_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_action,
   input  logic                       req_ev_tx_request,
   input  logic                       req_ev_rx_byte,
   input  logic                       req_ev_stop,
   input  logic                       req_ev_addr_match,
   input  logic                       req_master_reads,
   input  logic [ibe_pkg::DATA_W-1:0] req_rx_data,
   input  logic [ibe_pkg::POS_W-1:0]  req_load_index,
   input  logic [ibe_pkg::DATA_W-1:0] req_load_value,
   input  logic [ibe_pkg::PTR_W-1:0]  req_arm_length,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [ibe_pkg::DATA_W-1:0] rsp_data,
   output logic [ibe_pkg::POS_W-1:0]  rsp_position,
   output logic [ibe_pkg::PTR_W-1:0]  rsp_count,
   output logic                       rsp_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [3:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import ibe_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    csr_wr;

   logic    emit_valid;
   rsp_type emit;
   logic    emit_take;

   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (paddr[3:2])
            CSR_DEFAULT_BYTE: cfg_in.default_byte      = pwdata[DATA_W-1:0];
            CSR_RX_CAPACITY:  cfg_in.rx_capacity       = pwdata[PTR_W-1:0];
            CSR_RETRANSFER:   cfg_in.retransfer_enable = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         CSR_DEFAULT_BYTE: prdata = 32'(cfg_ff.default_byte);
         CSR_RX_CAPACITY:  prdata = 32'(cfg_ff.rx_capacity);
         CSR_RETRANSFER:   prdata = 32'(cfg_ff.retransfer_enable);
         default:          prdata = '0;
      endcase
   end

   ibe_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_ev_tx_request (req_ev_tx_request),
      .req_ev_rx_byte    (req_ev_rx_byte),
      .req_ev_stop       (req_ev_stop),
      .req_ev_addr_match (req_ev_addr_match),
      .req_master_reads  (req_master_reads),
      .req_rx_data       (req_rx_data),
      .req_load_index    (req_load_index),
      .req_load_value    (req_load_value),
      .req_arm_length    (req_arm_length),
      .cfg               (cfg_ff),
      .emit_valid        (emit_valid),
      .emit              (emit),
      .emit_take         (emit_take)
   );

   // advance a word into the output register when it is empty or being drained
   assign emit_take    = emit_valid && (!out_valid_ff || rsp_ready);
   assign out_in       = emit_take ? emit : out_ff;
   assign out_valid_in = emit_take ? 1'b1 : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_kind     = out_ff.kind;
   assign rsp_data     = out_ff.data;
   assign rsp_position = out_ff.position;
   assign rsp_count    = out_ff.count;
   assign rsp_last     = out_ff.last;

endmodule

[rtl/ibe_checker.sv]
module ibe_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_kind,
   input logic [ibe_pkg::DATA_W-1:0] rsp_data,
   input logic [ibe_pkg::POS_W-1:0]  rsp_position,
   input logic [ibe_pkg::PTR_W-1:0]  rsp_count,
   input logic                       rsp_last
);
   import ibe_pkg::*;

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data)
         && $stable(rsp_count) && $stable(rsp_last))
      else $error("rsp word changed while stalled");

   // tx complete is always followed by the default byte of the same request
   a_txdone_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_TXDONE) |-> !rsp_last)
      else $error("tx complete marked last");

   a_notice_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == KIND_TXDONE) || (rsp_kind == KIND_RXDONE))
         |-> (rsp_data == '0) && (rsp_position == '0))
      else $error("completion notice carries data");

   a_byte_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == KIND_TX) || (rsp_kind == KIND_RX)) |-> (rsp_count == '0))
      else $error("byte word carries a count");

endmodule

bind i2c_target_buffer_engine_top ibe_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_kind     (rsp_kind),
   .rsp_data     (rsp_data),
   .rsp_position (rsp_position),
   .rsp_count    (rsp_count),
   .rsp_last     (rsp_last)
);

[tb/sv/ibe_result_check.sv]
`timescale 1ns / 1ps

module ibe_result_check (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [1:0]                 req_action,
   input  logic                       req_ev_tx_request,
   input  logic                       req_ev_rx_byte,
   input  logic                       req_ev_stop,
   input  logic                       req_ev_addr_match,
   input  logic                       req_master_reads,
   input  logic [ibe_pkg::DATA_W-1:0] req_rx_data,
   input  logic [ibe_pkg::POS_W-1:0]  req_load_index,
   input  logic [ibe_pkg::DATA_W-1:0] req_load_value,
   input  logic [ibe_pkg::PTR_W-1:0]  req_arm_length,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [1:0]                 rsp_kind,
   input  logic [ibe_pkg::DATA_W-1:0] rsp_data,
   input  logic [ibe_pkg::POS_W-1:0]  rsp_position,
   input  logic [ibe_pkg::PTR_W-1:0]  rsp_count,
   input  logic                       rsp_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [3:0]                 paddr,
   input  logic [31:0]                pwdata,
   input  logic                       pready,
   output int                         fail_count,
   output int                         owed_count
);
   import ibe_pkg::*;

   logic [DATA_W-1:0] tx_mem [BUFFER_DEPTH];
   logic [PTR_W-1:0]  tx_len;
   logic [PTR_W-1:0]  tx_ptr;
   logic [PTR_W-1:0]  rx_ptr;
   logic              writing;
   cfg_type           regs;
   rsp_type           owed [$];
   int                mismatches = 0;

   function automatic void owe(input logic [1:0] kind, input logic [DATA_W-1:0] data,
                               input logic [POS_W-1:0] pos, input logic [PTR_W-1:0] cnt);
      rsp_type r;
      r.kind     = kind;
      r.data     = data;
      r.position = pos;
      r.count    = cnt;
      r.last     = 1'b0;
      owed.push_back(r);
   endfunction

   // flags are served in bus order: tx request, rx byte, stop, address match
   function automatic void take_event(input logic txr, input logic rxb, input logic stp,
                                      input logic adm, input logic reads,
                                      input logic [DATA_W-1:0] rxd);
      int                cur;
      int                final_idx;
      logic [PTR_W-1:0]  cap;
      logic [DATA_W-1:0] b;
      cur       = int'(tx_ptr);
      final_idx = int'(tx_len) - 1;
      if (txr) begin
         if (cur < final_idx) begin
            tx_ptr = tx_ptr + 1'b1;
            owe(KIND_TX, tx_mem[tx_ptr[ADDR_W-1:0]], '0, '0);
         end else if (cur == final_idx) begin
            owe(KIND_TXDONE, '0, '0, tx_ptr);
            owe(KIND_TX, regs.default_byte, '0, '0);
         end else begin
            owe(KIND_TX, regs.default_byte, '0, '0);
         end
      end
      if (rxb) begin
         cap = (regs.rx_capacity > RX_LIMIT) ? RX_LIMIT : regs.rx_capacity;
         if (rx_ptr < cap) begin
            owe(KIND_RX, rxd, rx_ptr[POS_W-1:0], '0);
            rx_ptr = rx_ptr + 1'b1;
         end
      end
      if (stp) begin
         if (writing) begin
            owe(KIND_RXDONE, '0, '0, rx_ptr);
            rx_ptr = '0;
         end else if (regs.retransfer_enable) begin
            tx_ptr = '0;
         end
      end
      if (adm) begin
         if (rx_ptr != '0) owe(KIND_RXDONE, '0, '0, rx_ptr);
         if (reads) begin
            b = (tx_ptr < tx_len) ? tx_mem[tx_ptr[ADDR_W-1:0]] : regs.default_byte;
            owe(KIND_TX, b, '0, '0);
            writing = 1'b0;
         end else begin
            writing = 1'b1;
            rx_ptr  = '0;
         end
      end
   endfunction

   always @(posedge clock) begin
      int      held;
      rsp_type got;
      rsp_type want;
      if (reset) begin
         tx_len  = '0;
         tx_ptr  = '0;
         rx_ptr  = '0;
         writing = 1'b0;
         regs    = '0;
         owed.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               CSR_DEFAULT_BYTE: regs.default_byte      = pwdata[DATA_W-1:0];
               CSR_RX_CAPACITY:  regs.rx_capacity       = pwdata[PTR_W-1:0];
               CSR_RETRANSFER:   regs.retransfer_enable = pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_action)
               ACT_LOAD: tx_mem[req_load_index] = req_load_value;
               ACT_ARM: begin
                  tx_len = (req_arm_length > PTR_W'(BUFFER_DEPTH)) ?
                           PTR_W'(BUFFER_DEPTH) : req_arm_length;
                  tx_ptr = '0;
               end
               ACT_EVENT: begin
                  held = owed.size();
                  take_event(req_ev_tx_request, req_ev_rx_byte, req_ev_stop,
                             req_ev_addr_match, req_master_reads, req_rx_data);
                  // flag the final word of this event
                  if (owed.size() > held) begin
                     want      = owed.pop_back();
                     want.last = 1'b1;
                     owed.push_back(want);
                  end
               end
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.kind     = rsp_kind;
            got.data     = rsp_data;
            got.position = rsp_position;
            got.count    = rsp_count;
            got.last     = rsp_last;
            if (owed.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unowed rsp word kind %0d data %02h pos %0d count %0d last %0d",
                           $realtime, got.kind, got.data, got.position, got.count, got.last);
            end else begin
               want = owed.pop_front();
               if (got.kind !== want.kind || got.data !== want.data ||
                   got.position !== want.position || got.count !== want.count ||
                   got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("%0t: rsp mismatch (exp/act) kind %0d/%0d data %02h/%02h ",
                            $realtime, want.kind, got.kind, want.data, got.data);
                     $display("pos %0d/%0d count %0d/%0d last %0d/%0d",
                              want.position, got.position, want.count, got.count,
                              want.last, got.last);
                  end
               end
            end
         end
      end
      fail_count <= mismatches;
      owed_count <= owed.size();
   end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import ibe_pkg::*;

   localparam logic [1:0] ACT_NONE = 2'd3;
   // transmit bytes loaded up front; randomly picked armed lengths stay within them
   localparam int FILL_DEPTH = 32;

   typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_TOGGLE} stall_type;

   typedef struct packed {
      logic [1:0]        action;
      logic              tx_req;
      logic              rx_byte;
      logic              stop;
      logic              addr_match;
      logic              reads;
      logic [DATA_W-1:0] rx_data;
      logic [POS_W-1:0]  load_index;
      logic [DATA_W-1:0] load_value;
      logic [PTR_W-1:0]  arm_length;
   } bus_word_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_action;
   logic              req_ev_tx_request;
   logic              req_ev_rx_byte;
   logic              req_ev_stop;
   logic              req_ev_addr_match;
   logic              req_master_reads;
   logic [DATA_W-1:0] req_rx_data;
   logic [POS_W-1:0]  req_load_index;
   logic [DATA_W-1:0] req_load_value;
   logic [PTR_W-1:0]  req_arm_length;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_kind;
   logic [DATA_W-1:0] rsp_data;
   logic [POS_W-1:0]  rsp_position;
   logic [PTR_W-1:0]  rsp_count;
   logic              rsp_last;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [3:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;
   int                fail_count;
   int                owed_count;

   logic      hold_go   = 1'b0;
   logic      hold_done = 1'b0;
   int        hold_left = 0;
   int        mode_left = 0;
   stall_type stall_mode = STALL_NONE;
   int        burst_left = 0;
   int        sent_items = 0;

   i2c_target_buffer_engine_top DUT (.*);
   ibe_result_check check_i (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // rsp side: random stall modes, plus one long hold-off to back up the input
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_type'($urandom_range(3, 0));
            mode_left  <= $urandom_range(150, 20);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_ready <= 1'b1;
            STALL_HALF:  rsp_ready <= 1'($urandom_range(1, 0));
            STALL_HEAVY: rsp_ready <= ($urandom_range(3, 0) == 0);
            default:     rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   function automatic bus_word_type any_word();
      bus_word_type w;
      w.action     = 2'($urandom_range(3, 0));
      w.tx_req     = 1'($urandom_range(1, 0));
      w.rx_byte    = 1'($urandom_range(1, 0));
      w.stop       = 1'($urandom_range(1, 0));
      w.addr_match = 1'($urandom_range(1, 0));
      w.reads      = 1'($urandom_range(1, 0));
      w.rx_data    = DATA_W'($urandom_range(255, 0));
      w.load_index = POS_W'($urandom_range(255, 0));
      w.load_value = DATA_W'($urandom_range(255, 0));
      w.arm_length = PTR_W'($urandom_range(511, 0));
      return w;
   endfunction

   function automatic bus_word_type event_word(input logic t, input logic r, input logic s,
                                               input logic a, input logic m);
      bus_word_type w;
      w            = any_word();
      w.action     = ACT_EVENT;
      w.tx_req     = t;
      w.rx_byte    = r;
      w.stop       = s;
      w.addr_match = a;
      if (a) w.reads = m;
      return w;
   endfunction

   function automatic bus_word_type load_word(input int idx, input int val);
      bus_word_type w;
      w            = any_word();
      w.action     = ACT_LOAD;
      w.load_index = POS_W'(idx);
      w.load_value = DATA_W'(val);
      return w;
   endfunction

   function automatic bus_word_type arm_word(input int len);
      bus_word_type w;
      w            = any_word();
      w.action     = ACT_ARM;
      w.arm_length = PTR_W'(len);
      return w;
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(99, 0);
      if (r < 70) return $urandom_range(12, 0);
      return $urandom_range(FILL_DEPTH, 13);
   endfunction

   // offer one word, hold it until taken, then maybe end the burst with a gap
   task automatic put_word(input bus_word_type w);
      int pick;
      req_valid         <= 1'b1;
      req_action        <= w.action;
      req_ev_tx_request <= w.tx_req;
      req_ev_rx_byte    <= w.rx_byte;
      req_ev_stop       <= w.stop;
      req_ev_addr_match <= w.addr_match;
      req_master_reads  <= w.reads;
      req_rx_data       <= w.rx_data;
      req_load_index    <= w.load_index;
      req_load_value    <= w.load_value;
      req_arm_length    <= w.arm_length;
      do @(posedge clock); while (!req_ready);
      if (w.action == ACT_LOAD || w.action == ACT_ARM ||
          (w.action == ACT_EVENT && (w.tx_req || w.rx_byte || w.stop || w.addr_match)))
         sent_items++;
      if (burst_left <= 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(10, 1)) @(posedge clock);
         pick = $urandom_range(9, 0);
         if (pick == 0)
            burst_left = $urandom_range(120, 60);
         else if (pick <= 3)
            burst_left = $urandom_range(30, 7);
         else
            burst_left = $urandom_range(6, 1);
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input int val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= 32'(val);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (owed_count != 0);
      // a word with no results may still be in flight
      repeat (12) @(posedge clock);
   endtask

   task automatic set_regs(input int dflt, input int cap, input int retx);
      drain();
      write_reg(CSR_DEFAULT_BYTE, dflt);
      write_reg(CSR_RX_CAPACITY, cap);
      write_reg(CSR_RETRANSFER, retx);
   endtask

   task automatic write_transfer(input int nbytes);
      put_word(event_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      for (int i = 0; i < nbytes; i++) put_word(event_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      case ($urandom_range(6, 0))
         0: ;
         1: put_word(event_word(1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
         default: put_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      endcase
   endtask

   task automatic read_transfer();
      int n;
      n = $urandom_range(10, 0);
      if ($urandom_range(1, 0)) put_word(arm_word(pick_length()));
      put_word(event_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
      for (int i = 0; i < n; i++) put_word(event_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      case ($urandom_range(6, 0))
         0: ;
         1: put_word(event_word(1'b1, 1'b0, 1'b1, 1'b0, 1'b0));
         default: put_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      endcase
   endtask

   task automatic run_traffic(input int n);
      int           r;
      bus_word_type w;
      sent_items = 0;
      while (sent_items < n) begin
         r = $urandom_range(99, 0);
         if (r < 40) begin
            write_transfer($urandom_range(7, 0));
         end else if (r < 75) begin
            read_transfer();
         end else if (r < 85) begin
            if ($urandom_range(1, 0))
               put_word(load_word($urandom_range(255, 0), $urandom_range(255, 0)));
            else
               put_word(arm_word(pick_length()));
         end else begin
            w = any_word();
            if (w.action == ACT_ARM) w.arm_length = PTR_W'(pick_length());
            put_word(w);
         end
      end
   endtask

   initial begin
      bus_word_type w;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_action        <= ACT_EVENT;
      req_ev_tx_request <= 1'b0;
      req_ev_rx_byte    <= 1'b0;
      req_ev_stop       <= 1'b0;
      req_ev_addr_match <= 1'b0;
      req_master_reads  <= 1'b0;
      req_rx_data       <= '0;
      req_load_index    <= '0;
      req_load_value    <= '0;
      req_arm_length    <= '0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_regs(8'hA5, 3, 0);
      // fill the low end of the transmit memory so that no read hits an unloaded byte
      for (int i = 0; i < FILL_DEPTH; i++) put_word(load_word(i, $urandom_range(255, 0)));

      w = any_word();
      w.action = ACT_NONE;
      {w.tx_req, w.rx_byte, w.stop, w.addr_match} = 4'hF;
      put_word(w);
      put_word(load_word(0, 8'h00));
      put_word(load_word(255, 8'hFF));
      // zero length: default byte on request and on read start
      put_word(arm_word(0));
      put_word(event_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      put_word(event_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
      // oversized arm saturates to full depth
      put_word(arm_word(511));
      put_word(event_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
      put_word(event_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      // final armed byte, then requests past it
      put_word(arm_word(2));
      repeat (3) put_word(event_word(1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
      put_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      // write past capacity, then stop
      put_word(event_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      w = event_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      w.rx_data = 8'h00;
      put_word(w);
      w.rx_data = 8'hFF;
      put_word(w);
      repeat (2) put_word(event_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      put_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
      // repeated start while bytes are held
      put_word(event_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      put_word(event_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      put_word(event_word(1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
      put_word(event_word(1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
      // every flag at once
      put_word(arm_word(1));
      put_word(event_word(1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
      put_word(event_word(1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
      w = load_word(7, 8'h3C);
      {w.tx_req, w.rx_byte, w.stop, w.addr_match} = 4'hF;
      put_word(w);

      set_regs(8'h00, 0, 1);
      run_traffic(25);
      set_regs(8'hFF, 256, 0);
      hold_go <= 1'b1;
      run_traffic(25);
      set_regs($urandom_range(255, 0), 9'h1FF, 1);
      write_transfer(258);
      run_traffic(25);
      set_regs($urandom_range(255, 0), $urandom_range(8, 1), $urandom_range(1, 0));
      run_traffic(25);
      set_regs($urandom_range(255, 0), $urandom_range(511, 0), $urandom_range(1, 0));
      run_traffic(25);

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && owed_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
